>>> rtl/msts_pkg.sv
// Package for the multi-slot timer scheduler: payload structs, operation and
// status codes, controller states and command/status structs.
// No dependencies.
`default_nettype none

package msts_pkg;

    localparam int NUM_SLOTS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_POLL   = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_STARTED   = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_CANCELLED = 3'd2,
        STAT_REJECTED  = 3'd3,
        STAT_FIRED     = 3'd4,
        STAT_NONE      = 3'd5
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] now;
        logic [31:0] delay;
        logic        repeat_req;
        logic [3:0]  slot_sel;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [2:0] slot;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic single;
        logic scan_step;
        logic flush;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic scan_blocked;
        logic scan_last;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/multi_slot_timer_scheduler.sv
// Top level of the multi-slot timer scheduler: ties the controller and the
// datapath together. Depends on msts_pkg, msts_ctrl and msts_dp.
`default_nettype none

// The block keeps a table of NUM_SLOTS timer slots and takes one operation
// per input transfer: start claims the lowest free slot and reports it (or
// table full), cancel frees the slot given by s_data.slot_sel (or rejects
// it), and poll reports every expired slot in index order, advancing periodic
// slots by one period and freeing one-shot slots. A slot is expired when
// (now - deadline) mod 2^32 is below half the range. Every operation ends
// with a result whose last bit is set; a poll with nothing expired returns a
// single none-fired result, and the unused operation code gives no result.
// Items are handled one at a time. A start or cancel is held in an input
// register and answered from the single state once the output register is
// free. A poll walks the slot table with one slot per cycle; the scan holds
// whenever a fired result waits for an output register that has not been
// emptied. Fired results are held one slot behind the scan so that the last
// one can be marked. Results sit in an output register, so a finished
// result may wait on m_ready while the block is already free. At most eight
// results come from one poll; with more than eight slots, later expired
// slots are still updated but not reported, and slot numbers are reported
// modulo eight.
module multi_slot_timer_scheduler #(
    parameter int NUM_SLOTS = msts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire msts_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output msts_pkg::out_item_t      m_data
);

    msts_pkg::ctrl_cmd_t cmd;
    msts_pkg::dp_stat_t  stat;

    msts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_kind (s_data.kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    msts_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> rtl/msts_ctrl.sv
// Controller state machine of the multi-slot timer scheduler.
// Depends on msts_pkg for states, codes and the command/status structs.
`default_nettype none

module msts_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire msts_pkg::kind_t   in_kind,
    output logic                   s_ready,
    input  wire msts_pkg::dp_stat_t stat,
    output msts_pkg::ctrl_cmd_t    cmd
);

    msts_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msts_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msts_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (in_kind)
                        msts_pkg::KIND_START,
                        msts_pkg::KIND_CANCEL: state_next = msts_pkg::ST_SINGLE;
                        msts_pkg::KIND_POLL:   state_next = msts_pkg::ST_SCAN;
                        default:               state_next = msts_pkg::ST_IDLE;
                    endcase
                end
            end
            msts_pkg::ST_SINGLE: begin
                if (stat.out_free) begin
                    state_next = msts_pkg::ST_IDLE;
                end
            end
            msts_pkg::ST_SCAN: begin
                if (!stat.scan_blocked && stat.scan_last) begin
                    state_next = msts_pkg::ST_FLUSH;
                end
            end
            msts_pkg::ST_FLUSH: begin
                if (stat.out_free) begin
                    state_next = msts_pkg::ST_IDLE;
                end
            end
            default: state_next = msts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.single    = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.flush     = 1'b0;
        unique case (state_reg)
            msts_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            msts_pkg::ST_SINGLE: cmd.single    = stat.out_free;
            msts_pkg::ST_SCAN:   cmd.scan_step = !stat.scan_blocked;
            msts_pkg::ST_FLUSH:  cmd.flush     = stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/msts_dp.sv
// Datapath of the multi-slot timer scheduler: slot table, scan counter,
// pending fired result and the output register. Depends on msts_pkg.
`default_nettype none

module msts_dp #(
    parameter int NUM_SLOTS = msts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire msts_pkg::in_item_t  s_data,
    input  wire msts_pkg::ctrl_cmd_t cmd,
    output msts_pkg::dp_stat_t       stat,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output msts_pkg::out_item_t      m_data
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(msts_pkg::MAX_RESULTS + 1);

    // Slot table. Only the active bits are reset; the rest is written by a
    // start before it is ever read.
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] periodic_reg;
    logic [31:0]          deadline_reg [NUM_SLOTS];
    logic [31:0]          period_reg   [NUM_SLOTS];

    msts_pkg::in_item_t   item_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 pend_valid_reg;
    logic [SLOT_W-1:0]    pend_slot_reg;
    logic [CNT_W-1:0]     count_reg;

    logic                 m_valid_reg, m_valid_next;
    msts_pkg::out_item_t  m_data_reg,  m_data_next;

    // Lowest free slot.
    logic                 full;
    logic [SLOT_W-1:0]    free_idx;

    always_comb begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                full     = 1'b0;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // Cancel index check.
    logic              sel_ok;
    logic [SLOT_W-1:0] sel_idx;

    assign sel_idx = SLOT_W'(item_reg.slot_sel);
    assign sel_ok  = ({1'b0, item_reg.slot_sel} < 5'(NUM_SLOTS)) && active_reg[sel_idx];

    // Expiry test of the slot under the scan counter.
    logic [31:0] diff;
    logic        fires;
    logic        record;

    assign diff   = item_reg.now - deadline_reg[idx_reg];
    assign fires  = active_reg[idx_reg] && (diff < msts_pkg::HALF_RANGE);
    assign record = fires && (count_reg < CNT_W'(msts_pkg::MAX_RESULTS));

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    assign stat.out_free     = out_free;
    assign stat.scan_blocked = record && pend_valid_reg && !out_free;
    assign stat.scan_last    = (idx_reg == SLOT_W'(NUM_SLOTS - 1));

    // Slot numbers are reported in the three-bit result field.
    function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] wide;
        wide = (SLOT_W + 3)'(idx);
        return wide[2:0];
    endfunction

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.single) begin
            m_valid_next = 1'b1;
            m_data_next.last = 1'b1;
            if (item_reg.kind == msts_pkg::KIND_START) begin
                m_data_next.status = full ? msts_pkg::STAT_FULL : msts_pkg::STAT_STARTED;
                m_data_next.slot   = full ? 3'd0 : slot_field(free_idx);
            end else begin
                m_data_next.status = sel_ok ? msts_pkg::STAT_CANCELLED
                                            : msts_pkg::STAT_REJECTED;
                m_data_next.slot   = sel_ok ? slot_field(sel_idx) : 3'd0;
            end
        end else if (cmd.scan_step && record && pend_valid_reg) begin
            m_valid_next       = 1'b1;
            m_data_next.status = msts_pkg::STAT_FIRED;
            m_data_next.slot   = slot_field(pend_slot_reg);
            m_data_next.last   = 1'b0;
        end else if (cmd.flush) begin
            m_valid_next       = 1'b1;
            m_data_next.status = pend_valid_reg ? msts_pkg::STAT_FIRED : msts_pkg::STAT_NONE;
            m_data_next.slot   = pend_valid_reg ? slot_field(pend_slot_reg) : 3'd0;
            m_data_next.last   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.load) begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
                count_reg      <= '0;
            end
            if (cmd.single) begin
                if (item_reg.kind == msts_pkg::KIND_START) begin
                    if (!full) begin
                        active_reg[free_idx] <= 1'b1;
                    end
                end else if (sel_ok) begin
                    active_reg[sel_idx] <= 1'b0;
                end
            end
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (fires && !periodic_reg[idx_reg]) begin
                    active_reg[idx_reg] <= 1'b0;
                end
                if (record) begin
                    pend_valid_reg <= 1'b1;
                    count_reg      <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.single && item_reg.kind == msts_pkg::KIND_START && !full) begin
            periodic_reg[free_idx] <= item_reg.repeat_req;
            deadline_reg[free_idx] <= item_reg.now + item_reg.delay;
            period_reg[free_idx]   <= item_reg.delay;
        end
        if (cmd.scan_step) begin
            if (record) begin
                pend_slot_reg <= idx_reg;
            end
            if (fires && periodic_reg[idx_reg]) begin
                deadline_reg[idx_reg] <= deadline_reg[idx_reg] + period_reg[idx_reg];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> bench/multi_slot_timer_scheduler_tb.sv
// Self-checking bench for the multi-slot timer scheduler: directed and random start, cancel
// and poll traffic with random stalls on both channels, checked against a slot-table tracker.
// Depends on msts_pkg and the multi_slot_timer_scheduler RTL.

class timer_table_tracker;
    bit        slot_busy[msts_pkg::NUM_SLOTS_DEF];
    bit        slot_repeats[msts_pkg::NUM_SLOTS_DEF];
    bit [31:0] slot_due[msts_pkg::NUM_SLOTS_DEF];
    bit [31:0] slot_interval[msts_pkg::NUM_SLOTS_DEF];
    msts_pkg::out_item_t due_results[$];
    int mismatches;

    function new();
        foreach (slot_busy[i]) slot_busy[i] = 1'b0;
        mismatches = 0;
    endfunction

    // Applies one accepted request to the slot table and queues the results it must cause.
    function void note_request(msts_pkg::in_item_t req);
        msts_pkg::out_item_t batch[$];
        msts_pkg::out_item_t res;
        int found;
        bit [31:0] lag;
        found = -1;
        res = '0;
        case (req.kind)
            msts_pkg::KIND_START: begin
                for (int i = 0; i < msts_pkg::NUM_SLOTS_DEF; i++) begin
                    if (!slot_busy[i]) begin
                        found = i;
                        break;
                    end
                end
                if (found >= 0) begin
                    slot_busy[found]     = 1'b1;
                    slot_repeats[found]  = req.repeat_req;
                    slot_due[found]      = req.now + req.delay;
                    slot_interval[found] = req.delay;
                    res.status = msts_pkg::STAT_STARTED;
                    res.slot   = found[2:0];
                end else begin
                    res.status = msts_pkg::STAT_FULL;
                end
                batch.push_back(res);
            end
            msts_pkg::KIND_CANCEL: begin
                if (req.slot_sel < msts_pkg::NUM_SLOTS_DEF && slot_busy[req.slot_sel]) begin
                    slot_busy[req.slot_sel] = 1'b0;
                    res.status = msts_pkg::STAT_CANCELLED;
                    res.slot   = req.slot_sel[2:0];
                end else begin
                    res.status = msts_pkg::STAT_REJECTED;
                end
                batch.push_back(res);
            end
            msts_pkg::KIND_POLL: begin
                for (int i = 0; i < msts_pkg::NUM_SLOTS_DEF; i++) begin
                    if (slot_busy[i]) begin
                        lag = req.now - slot_due[i];
                        if (lag < msts_pkg::HALF_RANGE) begin
                            if (batch.size() < msts_pkg::MAX_RESULTS) begin
                                res.status = msts_pkg::STAT_FIRED;
                                res.slot   = i[2:0];
                                batch.push_back(res);
                            end
                            if (slot_repeats[i]) slot_due[i] = slot_due[i] + slot_interval[i];
                            else slot_busy[i] = 1'b0;
                        end
                    end
                end
                if (batch.size() == 0) begin
                    res.status = msts_pkg::STAT_NONE;
                    res.slot   = 3'd0;
                    batch.push_back(res);
                end
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) due_results.push_back(batch[i]);
    endfunction

    function void check_result(msts_pkg::out_item_t got);
        msts_pkg::out_item_t want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d slot %0d last %0d",
                     $time, got.status, got.slot, got.last);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatches++;
        end
        if (got.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, actual %0d", $time, want.slot, got.slot);
            mismatches++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d", $time, want.last, got.last);
            mismatches++;
        end
    endfunction
endclass

module multi_slot_timer_scheduler_tb;
    import msts_pkg::*;

    localparam int RANDOM_ITEMS   = 380;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 24;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    timer_table_tracker tracker;
    int         items_sent  = 0;
    int         idle_cycles = 0;
    int         ready_hold  = 0;
    bit         quiet       = 1'b0;
    bit         paused_once = 1'b0;
    logic [31:0] cur_now;

    multi_slot_timer_scheduler #(.NUM_SLOTS(NUM_SLOTS_DEF)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // Gap lengths for both channels: mostly none or short, now and then a long one.
    // A quiet stretch turns all idling off so back-to-back transfers get exercised.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t make_req(kind_t k, logic [31:0] t, logic [31:0] d,
                                          logic r, logic [3:0] sel);
        in_item_t req;
        req.kind       = k;
        req.now        = t;
        req.delay      = d;
        req.repeat_req = r;
        req.slot_sel   = sel;
        return req;
    endfunction

    // Offers one request and returns once its transfer has happened. Valid is only
    // lowered when a gap follows, so it never drops and rises within one time step.
    task automatic send_item(input in_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(req);
        if (req.kind != KIND_RSVD) items_sent++;
    endtask

    // Fields that an operation does not use carry random values; the block must ignore them.
    task automatic do_start(input logic [31:0] t, input logic [31:0] d, input logic r);
        send_item(make_req(KIND_START, t, d, r, 4'($urandom)));
    endtask

    task automatic do_cancel(input logic [3:0] sel);
        send_item(make_req(KIND_CANCEL, $urandom, $urandom, 1'($urandom), sel));
    endtask

    task automatic do_poll(input logic [31:0] t);
        send_item(make_req(KIND_POLL, t, $urandom, 1'($urandom), 4'($urandom)));
    endtask

    // The sender holds off until every queued result has been seen.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.due_results.size() != 0);
    endtask

    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'd0;
        if (r == 1) return $urandom;
        if (r == 2) return 32'h7FFF_FF00 + $urandom_range(0, 511);
        return $urandom_range(1, 150);
    endfunction

    // One operation on a clock that mostly moves forward in small steps.
    task automatic single_op();
        int op;
        op = $urandom_range(0, 9);
        if ($urandom_range(0, 19) == 0) cur_now = cur_now + $urandom_range(0, 32'h7FFF_FFFF);
        else cur_now = cur_now + $urandom_range(0, 60);
        if (op < 4) begin
            do_start(cur_now, pick_delay(), 1'($urandom));
        end else if (op < 6) begin
            if ($urandom_range(0, 99) < 85) do_cancel(4'($urandom_range(0, 7)));
            else do_cancel(4'($urandom_range(8, 15)));
        end else begin
            do_poll(cur_now);
        end
    endtask

    // Clears the table, fills it with short timers, overflows it and polls, so that a
    // single poll can report every slot.
    task automatic fill_and_poll();
        for (int i = 0; i < NUM_SLOTS_DEF; i++) do_cancel(4'(i));
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
            do_start(cur_now, $urandom_range(0, 8), 1'($urandom));
        do_start(cur_now, $urandom_range(0, 8), 1'($urandom));
        cur_now = cur_now + $urandom_range(0, 12);
        do_poll(cur_now);
        cur_now = cur_now + $urandom_range(0, 12);
        do_poll(cur_now);
    endtask

    // A short-period repeating timer polled late, then again at the same time, so that
    // its deadline has to catch up one period per poll.
    task automatic late_catchup();
        do_start(cur_now, $urandom_range(1, 5), 1'b1);
        cur_now = cur_now + $urandom_range(20, 100);
        repeat ($urandom_range(2, 4)) do_poll(cur_now);
    endtask

    // Anything at all, including the unused operation code.
    task automatic noise_item();
        send_item(make_req(kind_t'($urandom_range(0, 3)), $urandom, $urandom,
                           1'($urandom), 4'($urandom)));
    endtask

    // Result side: random stalls, checked on every transfer. Reading the outputs right
    // after the edge sees their values from before it, since the block updates them late
    // in the same step.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold = 0;
        end else begin
            if (m_valid && m_ready) tracker.check_result(m_data);
            if (ready_hold > 0) begin
                m_ready <= 1'b0;
                ready_hold--;
            end else if ($urandom_range(0, 2) == 0 && pick_gap() > 0) begin
                m_ready    <= 1'b0;
                ready_hold = pick_gap();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles in a row without a transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int pick;
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty table, bad cancels, a full table with deadlines around the
        // wrap and the half-range boundary, a repeating timer with period zero, exact
        // deadline hits, double cancel, late polls and the unused operation code.
        do_poll(32'd0);
        do_cancel(4'd0);
        do_cancel(4'd15);
        do_cancel(4'd8);
        do_start(32'd0, 32'd100, 1'b0);
        do_start(32'd0, 32'd0, 1'b1);
        do_start(32'hFFFF_FFF0, 32'h20, 1'b1);
        do_start(32'd5, 32'hFFFF_FFFF, 1'b0);
        do_start(32'd0, 32'h7FFF_FFFF, 1'b1);
        do_start(32'd0, 32'h8000_0000, 1'b0);
        do_start(32'd0, 32'd3, 1'b1);
        do_start(32'd0, 32'd3, 1'b0);
        do_start(32'd0, 32'd1, 1'b1);
        do_poll(32'd99);
        do_poll(32'd100);
        do_cancel(4'd7);
        do_cancel(4'd7);
        do_poll(32'hFFFF_FFFF);
        send_item(make_req(KIND_RSVD, '1, '1, 1'b1, 4'hF));
        send_item(make_req(KIND_RSVD, '0, '0, 1'b0, 4'h0));
        do_poll(32'h8000_0000);
        do_poll(32'h8000_0003);
        drain_results();

        // Random part: mostly coherent sequences on a moving clock, some raw noise.
        items_sent = 0;
        cur_now    = $urandom;
        while (items_sent < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 7) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 60) single_op();
            else if (pick < 72) fill_and_poll();
            else if (pick < 85) late_catchup();
            else noise_item();
            if ($urandom_range(0, 39) == 0) cur_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
            if (!paused_once && items_sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                paused_once = 1'b1;
            end
        end
        quiet = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
